// ----- hdl/aacf_pkg.sv -----
// ----------------------------------------------------------------------------
// aacf_pkg: shared types and constants of the alpha-aware convolution filter
// Holds the configuration register indexes, datapath widths and the control
// bundle that the sequencer sends to the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package aacf_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_TAPS_LOW  = 3'd0;
	localparam logic [2:0] REG_TAPS_MID  = 3'd1;
	localparam logic [2:0] REG_TAPS_HIGH = 3'd2;
	localparam logic [2:0] REG_DIVISOR   = 3'd3;
	localparam logic [2:0] REG_BIAS      = 3'd4;
	localparam logic [2:0] REG_CH_MASK   = 3'd5;
	localparam logic [2:0] REG_GRAY_MODE = 3'd6;
	localparam logic [2:0] REG_CENTER    = 3'd7;

	// Datapath widths.
	localparam int COEF_W = 16;
	localparam int SUM_W  = 32;
	localparam int RDIV_W = 21;
	localparam int QUO_W  = 34;

	// Channel numbers in pixel order.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	// Largest channel value after clamping.
	localparam int CHAN_MAX = 255;

	// Control bundle from the sequencer to the accumulator.
	typedef struct packed {
		logic                     clear;
		logic                     add;
		logic [1:0]               ch;
		logic [7:0]               chan;
		logic signed [COEF_W-1:0] coef;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/aacf_mac.sv -----
// ----------------------------------------------------------------------------
// aacf_mac: shared multiply-accumulate unit
// Holds the four channel sums and adds one channel value times one
// coefficient to the selected sum per cycle while add is set.
// ----------------------------------------------------------------------------
`default_nettype none

module aacf_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire aacf_pkg::mac_ctl_t                ctl,
	output logic signed [aacf_pkg::SUM_W-1:0]      sum
);

	logic signed [aacf_pkg::SUM_W-1:0] sum_q [4];
	logic signed [24:0]                prod;

	// One 9x16 signed product per cycle.
	assign prod = $signed({1'b0, ctl.chan}) * ctl.coef;

	// The selected sum is read for both accumulation and division.
	assign sum = sum_q[ctl.ch];

	// Channel sums, cleared at the first tap of a neighborhood.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) sum_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < 4; i++) sum_q[i] <= '0;
		end else if (ctl.add) begin
			sum_q[ctl.ch] <= sum_q[ctl.ch] + aacf_pkg::SUM_W'(prod);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/aacf_div.sv -----
// ----------------------------------------------------------------------------
// aacf_div: iterative signed divider
// Divides a 32-bit sum by a 21-bit divisor one quotient bit per cycle,
// truncating toward zero. The result is valid while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module aacf_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [aacf_pkg::SUM_W-1:0]  dividend,
	input  wire logic signed [aacf_pkg::RDIV_W-1:0] divisor,
	output logic                                    done,
	output logic signed [aacf_pkg::QUO_W-1:0]       quotient
);

	localparam int SW = aacf_pkg::SUM_W;
	localparam int DW = aacf_pkg::RDIV_W;

	logic                  busy_q;
	logic                  done_q;
	logic [4:0]            cnt_q;
	logic [SW-1:0]         work_q;
	logic [DW-1:0]         rem_q;
	logic [DW-1:0]         dvs_q;
	logic                  neg_q;
	logic [DW+1:0]         trial;
	logic signed [aacf_pkg::QUO_W-1:0] qmag;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {1'b0, rem_q, work_q[SW-1]} - {2'b0, dvs_q};

	// Restore the sign on the magnitude quotient.
	assign qmag     = {2'b0, work_q};
	assign quotient = neg_q ? -qmag : qmag;
	assign done     = done_q;

	// Restoring division over the dividend bits, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			dvs_q  <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
			rem_q  <= '0;
			neg_q  <= dividend[SW-1] ^ divisor[DW-1];
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q  <= trial[DW-1:0];
				work_q <= {work_q[SW-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[DW-2:0], work_q[SW-1]};
				work_q <= {work_q[SW-2:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/alpha_aware_convolution_filter_top.sv -----
// ----------------------------------------------------------------------------
// alpha_aware_convolution_filter_top: alpha-aware convolution kernel
// Accumulates weighted neighborhood pixels and emits one filtered pixel.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one neighborhood pixel per transfer in row-major
// kernel order, with s_tlast on the final pixel. Each last pixel produces
// one result transfer: m_tdata is the filtered pixel and m_tuser is set when
// the centre pixel was passed through unchanged.
// Each tap is taken in the transfer cycle and then runs through the shared
// multiply-accumulate unit, one channel at a time. On the last tap each
// divided channel then runs through the shared bit-serial divider, each
// copied channel takes its centre value, and the output register loads. A
// passed through centre skips the divider and goes straight to that load.
// s_tready is low while a tap is in work. A finished result sits in the
// output register; the next pixels are taken meanwhile, and only a following
// result waits while m_tready is low. Reset clears the sums and tap count,
// loads the register defaults and drops m_tvalid. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_aware_convolution_filter_top #(
	parameter int KERNEL_TAPS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [63:0] cfg_data,
	// Input stream. tdata: pixel[31:0]. tlast: last_tap.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tlast,
	// Output stream. tdata: result_pixel[31:0]. tuser: passed_through.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic             m_tuser
);

	localparam int TW = $clog2(KERNEL_TAPS + 1);
	localparam int CW = aacf_pkg::COEF_W;
	localparam int RW = aacf_pkg::RDIV_W;
	localparam int QW = aacf_pkg::QUO_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_FIN,
		ST_DWAIT,
		ST_EMIT
	} state_t;

	// Configuration registers.
	logic [63:0]          taps_q [3];
	logic signed [CW-1:0] div_cfg_q;
	logic signed [CW-1:0] bias_q;
	logic [3:0]           mask_q;
	logic                 gray_q;
	logic [3:0]           ctap_q;

	// Sequencer and tap state.
	state_t               state_q;
	logic [TW-1:0]        tap_cnt_q;
	logic signed [RW-1:0] rdiv_q;
	logic [31:0]          centre_q;
	logic [31:0]          pix_q;
	logic                 last_q;
	logic signed [CW-1:0] coef_q;
	logic                 en_q;
	logic [1:0]           ch_q;
	logic [7:0]           res_q [4];
	logic                 pass_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;
	logic                 m_tuser_q;

	logic                 accept;
	logic [3:0]           tap4;
	logic                 in_range;
	logic signed [CW-1:0] coef_in;
	logic [7:0]           alpha_in;
	logic signed [RW-1:0] base_div;
	aacf_pkg::mac_ctl_t   mac_ctl;
	logic signed [aacf_pkg::SUM_W-1:0] sum;
	logic                 div_start;
	logic                 div_done;
	logic signed [RW-1:0] div_dvs;
	logic signed [QW-1:0] quotient;
	logic signed [QW-1:0] biased;
	logic [7:0]           clamped;
	logic                 ch_div;
	logic [7:0]           ch_centre;
	logic [7:0]           ch_val;
	logic                 ch_active;
	logic                 emit_ok;
	logic [31:0]          result;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Coefficient and alpha of the incoming tap.
	assign tap4     = 4'(tap_cnt_q);
	assign in_range = tap_cnt_q < TW'(KERNEL_TAPS);
	assign alpha_in = gray_q ? s_tdata[15:8] : s_tdata[31:24];
	assign base_div = (tap_cnt_q == '0) ? RW'(div_cfg_q) : rdiv_q;

	always_comb begin
		unique case (tap4[3:2])
			2'd0:    coef_in = taps_q[0][{tap4[1:0], 4'b0} +: CW];
			2'd1:    coef_in = taps_q[1][{tap4[1:0], 4'b0} +: CW];
			2'd2:    coef_in = taps_q[2][{tap4[1:0], 4'b0} +: CW];
			default: coef_in = '0;
		endcase
	end

	// Channel selection for the accumulator and the final pass.
	always_comb begin
		unique case (ch_q)
			aacf_pkg::CH_RED: begin
				ch_val    = pix_q[7:0];
				ch_centre = centre_q[7:0];
				ch_div    = mask_q[0];
				ch_active = 1'b1;
			end
			aacf_pkg::CH_GREEN: begin
				ch_val    = pix_q[15:8];
				ch_centre = gray_q ? 8'd0 : centre_q[15:8];
				ch_div    = !gray_q && mask_q[1];
				ch_active = !gray_q;
			end
			aacf_pkg::CH_BLUE: begin
				ch_val    = pix_q[23:16];
				ch_centre = gray_q ? 8'd0 : centre_q[23:16];
				ch_div    = !gray_q && mask_q[2];
				ch_active = !gray_q;
			end
			default: begin
				ch_val    = gray_q ? pix_q[15:8] : pix_q[31:24];
				ch_centre = gray_q ? centre_q[15:8] : centre_q[31:24];
				ch_div    = mask_q[3] && (div_cfg_q != '0);
				ch_active = 1'b1;
			end
		endcase
	end

	// Accumulator control.
	always_comb begin
		mac_ctl.clear = accept && (tap_cnt_q == '0);
		mac_ctl.add   = (state_q == ST_MAC) && en_q && ch_active;
		mac_ctl.ch    = ch_q;
		mac_ctl.chan  = ch_val;
		mac_ctl.coef  = coef_q;
	end

	aacf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sum    (sum)
	);

	// Alpha divides by the configured divisor, colors by the running one.
	assign div_dvs   = (ch_q == aacf_pkg::CH_ALPHA) ? RW'(div_cfg_q) : rdiv_q;
	assign div_start = (state_q == ST_FIN) && (rdiv_q != '0) && ch_div;

	aacf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quotient)
	);

	// Add the bias and clamp to one byte.
	assign biased = quotient + QW'(bias_q);
	always_comb begin
		priority if (biased < 0) begin
			clamped = 8'd0;
		end else if (biased > QW'(aacf_pkg::CHAN_MAX)) begin
			clamped = 8'(aacf_pkg::CHAN_MAX);
		end else begin
			clamped = biased[7:0];
		end
	end

	// Output pixel in the input packing.
	always_comb begin
		if (pass_q) begin
			result = gray_q ? {16'd0, centre_q[15:0]} : centre_q;
		end else if (gray_q) begin
			result = {16'd0, res_q[3], res_q[0]};
		end else begin
			result = {res_q[3], res_q[2], res_q[1], res_q[0]};
		end
	end

	assign emit_ok = !m_tvalid_q || m_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q[0] <= '0;
			taps_q[1] <= '0;
			taps_q[2] <= '0;
			div_cfg_q <= 16'sd1;
			bias_q    <= '0;
			mask_q    <= 4'hf;
			gray_q    <= 1'b0;
			ctap_q    <= 4'd4;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				aacf_pkg::REG_TAPS_LOW:  taps_q[0] <= cfg_data;
				aacf_pkg::REG_TAPS_MID:  taps_q[1] <= cfg_data;
				aacf_pkg::REG_TAPS_HIGH: taps_q[2] <= cfg_data;
				aacf_pkg::REG_DIVISOR:   div_cfg_q <= cfg_data[15:0];
				aacf_pkg::REG_BIAS:      bias_q    <= cfg_data[15:0];
				aacf_pkg::REG_CH_MASK:   mask_q    <= cfg_data[3:0];
				aacf_pkg::REG_GRAY_MODE: gray_q    <= cfg_data[0];
				aacf_pkg::REG_CENTER:    ctap_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer: tap intake, channel accumulation, division and emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tap_cnt_q  <= '0;
			rdiv_q     <= RW'(1);
			centre_q   <= '0;
			pix_q      <= '0;
			last_q     <= 1'b0;
			coef_q     <= '0;
			en_q       <= 1'b0;
			ch_q       <= '0;
			for (int i = 0; i < 4; i++) res_q[i] <= '0;
			pass_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			// A taken result frees the output register unless a new one loads now.
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pix_q  <= s_tdata;
						last_q <= s_tlast;
						coef_q <= coef_in;
						en_q   <= in_range && (coef_in != '0) && (alpha_in != '0);
						ch_q   <= '0;
						pass_q <= 1'b0;
						if (in_range && (coef_in != '0) && (alpha_in == '0)) begin
							rdiv_q <= base_div - RW'(coef_in);
						end else begin
							rdiv_q <= base_div;
						end
						if (in_range && (tap4 == ctap_q)) begin
							centre_q <= s_tdata;
						end else if (tap_cnt_q == '0) begin
							centre_q <= '0;
						end
						if (s_tlast) begin
							tap_cnt_q <= '0;
						end else if (in_range) begin
							tap_cnt_q <= tap_cnt_q + TW'(1);
						end
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					ch_q <= ch_q + 2'd1;
					if (ch_q == aacf_pkg::CH_ALPHA) begin
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (rdiv_q == '0) begin
						pass_q  <= 1'b1;
						state_q <= ST_EMIT;
					end else if (ch_div) begin
						state_q <= ST_DWAIT;
					end else begin
						res_q[ch_q] <= ch_centre;
						ch_q        <= ch_q + 2'd1;
						if (ch_q == aacf_pkg::CH_ALPHA) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						res_q[ch_q] <= clamped;
						ch_q        <= ch_q + 2'd1;
						state_q     <= (ch_q == aacf_pkg::CH_ALPHA) ? ST_EMIT : ST_FIN;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= result;
						m_tuser_q  <= pass_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/aacf_checker.sv -----
// ----------------------------------------------------------------------------
// aacf_checker: port-level checks of the convolution filter
// Watches the stream ports for result hold and the busy window of a tap.
// ----------------------------------------------------------------------------
`default_nettype none

module aacf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Each accepted tap keeps s_tready low while the accumulator works through its channels.
	a_tap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken while a tap is still accumulating");

	// A new result only appears at the end of a busy period.
	a_emit_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a preceding busy period");

endmodule

bind alpha_aware_convolution_filter_top aacf_checker u_aacf_checker (.*);

`default_nettype wire
